// ----- rtl/cscb_pkg.sv -----
// ----------------------------------------------------------------------------
// cscb_pkg: shared definitions of the comment and literal blanker
// Character codes, scan modes, the per-beat result bundle that the scanner
// hands to the output queue, and small character helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cscb_pkg;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Default number of byte entries held between the scanner and the output.
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_SLASH = 3'd1,
    MODE_LINE  = 3'd2,
    MODE_BLOCK = 3'd3,
    MODE_BSTAR = 3'd4,
    MODE_LIT   = 3'd5,
    MODE_LESC  = 3'd6
  } scan_mode_e;

  // Result of one accepted beat: zero, one or two output bytes.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] item0;
    logic [7:0] item1;
    logic       last;
  } scan_res_t;

  function automatic logic is_quote(input logic [7:0] b);
    return (b == CH_DQUOTE) || (b == CH_SQUOTE);
  endfunction

  // Output byte of a plain text byte that does not start a held slash.
  function automatic logic [7:0] plain_out(input logic [7:0] b);
    return is_quote(b) ? CH_SPACE : b;
  endfunction

  // Newlines survive inside comments and literals, everything else blanks.
  function automatic logic [7:0] keep_nl(input logic [7:0] b);
    return (b == CH_NL) ? CH_NL : CH_SPACE;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cscb_scan.sv -----
// ----------------------------------------------------------------------------
// cscb_scan: lexical mode tracker
// Holds the scan mode and quote kind, and turns each accepted beat into zero,
// one or two output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module cscb_scan (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         data_i,
  input  wire logic               last_i,
  output cscb_pkg::scan_res_t     res_o
);
  import cscb_pkg::*;

  scan_mode_e mode_q, mode_d;
  logic       quote_q, quote_d;
  logic [7:0] quote_ch;
  logic [1:0] cnt;
  logic [7:0] item0, item1;

  assign quote_ch = quote_q ? CH_SQUOTE : CH_DQUOTE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_PLAIN;
      quote_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
    end
  end

  // Next state.
  always_comb begin
    mode_d  = mode_q;
    quote_d = quote_q;
    if (accept_i) begin
      unique case (mode_q)
        MODE_SLASH: begin
          if (data_i == CH_SLASH) begin
            mode_d = MODE_LINE;
          end else if (data_i == CH_STAR) begin
            mode_d = MODE_BLOCK;
          end else if (is_quote(data_i)) begin
            mode_d  = MODE_LIT;
            quote_d = (data_i == CH_SQUOTE);
          end else begin
            mode_d = MODE_PLAIN;
          end
        end
        MODE_LINE: begin
          if (data_i == CH_NL) mode_d = MODE_PLAIN;
        end
        MODE_BLOCK, MODE_BSTAR: begin
          if (mode_q == MODE_BSTAR && data_i == CH_SLASH) begin
            mode_d = MODE_PLAIN;
          end else if (data_i == CH_STAR) begin
            mode_d = MODE_BSTAR;
          end else begin
            mode_d = MODE_BLOCK;
          end
        end
        MODE_LIT: begin
          if (data_i == quote_ch) begin
            mode_d = MODE_PLAIN;
          end else if (data_i == CH_BSLASH) begin
            mode_d = MODE_LESC;
          end
        end
        MODE_LESC: begin
          mode_d = MODE_LIT;
        end
        default: begin
          if (data_i == CH_SLASH && !last_i) begin
            mode_d = MODE_SLASH;
          end else if (is_quote(data_i)) begin
            mode_d  = MODE_LIT;
            quote_d = (data_i == CH_SQUOTE);
          end else begin
            mode_d = MODE_PLAIN;
          end
        end
      endcase
      // The end of a text returns the scanner to its reset state.
      if (last_i) begin
        mode_d  = MODE_PLAIN;
        quote_d = 1'b0;
      end
    end
  end

  // Output bytes.
  always_comb begin
    cnt   = 2'd1;
    item0 = CH_SPACE;
    item1 = CH_SPACE;
    unique case (mode_q)
      MODE_SLASH: begin
        cnt = 2'd2;
        if (data_i != CH_SLASH && data_i != CH_STAR) begin
          item0 = CH_SLASH;
          item1 = plain_out(data_i);
        end
      end
      MODE_LINE, MODE_BLOCK, MODE_BSTAR, MODE_LIT: begin
        item0 = keep_nl(data_i);
      end
      MODE_LESC: begin
        item0 = CH_SPACE;
      end
      default: begin
        if (data_i == CH_SLASH && !last_i) begin
          cnt = 2'd0;
        end else begin
          item0 = plain_out(data_i);
        end
      end
    endcase
  end

  assign res_o.cnt   = accept_i ? cnt : 2'd0;
  assign res_o.item0 = item0;
  assign res_o.item1 = item1;
  assign res_o.last  = last_i;

  // A final beat always yields at least one byte to carry the end mark.
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |-> res_o.cnt != 2'd0)
    else $error("final beat produced no output byte");

  // After a final beat the next text starts in plain mode.
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> mode_q == MODE_PLAIN && !quote_q)
    else $error("scanner state not cleared after final beat");

  // Two bytes come out only when a held slash is resolved.
  a_pair_from_slash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.cnt == 2'd2 |-> mode_q == MODE_SLASH)
    else $error("two output bytes outside held slash");

endmodule

`default_nettype wire

// ----- rtl/cscb_outq.sv -----
// ----------------------------------------------------------------------------
// cscb_outq: output queue
// Small register queue that takes up to two bytes per cycle from the scanner
// and delivers one beat per cycle on the output channel while it is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module cscb_outq #(
  parameter int unsigned Depth = cscb_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  cscb_pkg::scan_res_t     push_i,
  output logic                    nearly_full_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              out_byte_o,
  output logic                    out_last_o
);
  import cscb_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [7:0]      data_q [Depth];
  logic            last_q [Depth];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d, wp_1;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign pop         = out_valid_o && !out_stall_i;
  assign wp_1        = ptr_inc(wp_q);
  assign out_valid_o = (cnt_q != '0);
  assign out_byte_o  = data_q[rp_q];
  assign out_last_o  = last_q[rp_q];

  // Room for a worst-case pair of bytes is needed before a beat is taken.
  assign nearly_full_o = (cnt_q > CntW'(Depth - 2));

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q + CntW'(push_i.cnt);
    if (push_i.cnt == 2'd1) wp_d = wp_1;
    if (push_i.cnt == 2'd2) wp_d = ptr_inc(wp_1);
    if (pop) begin
      rp_d  = ptr_inc(rp_q);
      cnt_d = cnt_d - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      data_q[wp_q] <= push_i.item0;
      last_q[wp_q] <= push_i.last && (push_i.cnt == 2'd1);
    end
    if (push_i.cnt == 2'd2) begin
      data_q[wp_1] <= push_i.item1;
      last_q[wp_1] <= push_i.last;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |->
      ({1'b0, cnt_q} + (CntW + 1)'(push_i.cnt)) <= (CntW + 1)'(Depth))
    else $error("queue written while full");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && push_i.cnt == 2'd0 |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("fill count did not drop on a pop");

endmodule

`default_nettype wire

// ----- rtl/c_source_comment_string_blanker_top.sv -----
// ----------------------------------------------------------------------------
// c_source_comment_string_blanker_top: C comment and literal blanker
// Streams a C or C++ source text and replaces comments and quoted literals
// with spaces while keeping the text length and line structure.
// ----------------------------------------------------------------------------
// The block takes one source byte per beat and returns a text of the same
// length in which the bytes of line comments, block comments, and double- or
// single-quoted literals, their delimiters and every backslash escape pair
// are replaced by spaces; newlines inside them are kept, except a newline
// that directly follows a backslash in a literal. A slash in plain text is
// held back by one beat to see whether it opens a comment, so a beat can
// yield no output byte (the held slash), one byte, or two bytes (the held
// slash resolved together with the byte after it). The end mark src_last_i
// travels to the final output byte of that text, a slash on the final byte
// is passed unchanged, and the scanner returns to plain text after it, so
// texts may follow each other with no gap. Input beats are taken at one per
// clock: the scan mode update is a small state machine that completes in the
// cycle a beat is accepted, and its bytes enter an output queue of Depth
// entries. The input is stalled only while fewer than two entries are free,
// which with an output that takes a beat every cycle never happens, so the
// sustained rate is one byte per cycle in and out. The bytes of an accepted
// beat are registered in the queue before they reach the output.
// ----------------------------------------------------------------------------
`default_nettype none

module c_source_comment_string_blanker_top #(
  // Output queue entries; at least 4 for full rate.
  parameter int unsigned Depth = cscb_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       src_valid_i,
  output logic            src_stall_o,
  input  wire logic [7:0] src_byte_i,
  input  wire logic       src_last_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);
  import cscb_pkg::*;

  logic      src_accept;
  logic      nearly_full;
  scan_res_t scan_res;

  // Stall depends only on queue occupancy, never on the input valid.
  assign src_stall_o = nearly_full;
  assign src_accept  = src_valid_i && !src_stall_o;

  cscb_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (src_accept),
    .data_i   (src_byte_i),
    .last_i   (src_last_i),
    .res_o    (scan_res)
  );

  cscb_outq #(
    .Depth (Depth)
  ) u_outq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (scan_res),
    .nearly_full_o (nearly_full),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .out_last_o    (out_last_o)
  );

endmodule

`default_nettype wire

// ----- tb/c_source_comment_string_blanker_top_tb.sv -----
// ----------------------------------------------------------------------------
// c_source_comment_string_blanker_top_tb: self-checking bench of the blanker
// Sends directed and random C-like source texts through the blanker and
// compares every output beat with a cycle-free model of the scanner. The
// model is held in a small scoreboard, and both channels idle at random.
// ----------------------------------------------------------------------------
module c_source_comment_string_blanker_top_tb;

  import cscb_pkg::*;

  // Cycles with no accepted beat on either side before the run is abandoned.
  localparam int unsigned QUIET_LIMIT = 5000;
  // Random input beats per idling phase.
  localparam int unsigned PHASE_BEATS = 400;
  localparam int unsigned NUM_PHASES  = 4;

  // One output beat of the blanked text.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } blank_beat_t;

  // The scoreboard mirrors the scanner state and keeps the blanked bytes
  // that the block still owes us, oldest first.
  class blank_scoreboard;
    scan_mode_e  mode;
    bit          single_quote;
    blank_beat_t blanked_q[$];
    int          errors;

    function new();
      mode         = MODE_PLAIN;
      single_quote = 1'b0;
      errors       = 0;
    endfunction

    task report(string field, logic [7:0] want, logic [7:0] got);
      $display("ERROR: %s expected %02h got %02h", field, want, got);
      errors++;
    endtask

    function int pending();
      return blanked_q.size();
    endfunction

    // A plain text byte that cannot start a held slash: a quote opens a
    // literal and is itself blanked.
    function void plain_text(logic [7:0] b, ref logic [7:0] outs[$]);
      if (b == CH_DQUOTE || b == CH_SQUOTE) begin
        single_quote = (b == CH_SQUOTE);
        mode         = MODE_LIT;
        outs.insert(outs.size(), CH_SPACE);
      end else begin
        mode = MODE_PLAIN;
        outs.insert(outs.size(), b);
      end
    endfunction

    // Work out the bytes that one accepted input beat gives.
    function void note_input(logic [7:0] b, logic l);
      logic [7:0]  outs[$];
      logic [7:0]  closer;
      blank_beat_t beat;
      closer = single_quote ? CH_SQUOTE : CH_DQUOTE;
      case (mode)
        MODE_SLASH: begin
          if (b == CH_SLASH || b == CH_STAR) begin
            outs.insert(outs.size(), CH_SPACE);
            outs.insert(outs.size(), CH_SPACE);
            mode = (b == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
          end else begin
            // The held slash was ordinary text after all.
            outs.insert(outs.size(), CH_SLASH);
            plain_text(b, outs);
          end
        end
        MODE_LINE: begin
          if (b == CH_NL) begin
            outs.insert(outs.size(), CH_NL);
            mode = MODE_PLAIN;
          end else begin
            outs.insert(outs.size(), CH_SPACE);
          end
        end
        MODE_BLOCK, MODE_BSTAR: begin
          if (mode == MODE_BSTAR && b == CH_SLASH) begin
            outs.insert(outs.size(), CH_SPACE);
            mode = MODE_PLAIN;
          end else if (b == CH_STAR) begin
            outs.insert(outs.size(), CH_SPACE);
            mode = MODE_BSTAR;
          end else begin
            outs.insert(outs.size(), (b == CH_NL) ? CH_NL : CH_SPACE);
            mode = MODE_BLOCK;
          end
        end
        MODE_LIT: begin
          if (b == closer) begin
            outs.insert(outs.size(), CH_SPACE);
            mode = MODE_PLAIN;
          end else if (b == CH_BSLASH) begin
            outs.insert(outs.size(), CH_SPACE);
            mode = MODE_LESC;
          end else begin
            outs.insert(outs.size(), (b == CH_NL) ? CH_NL : CH_SPACE);
          end
        end
        MODE_LESC: begin
          // Second byte of an escape pair, a newline included, is blanked.
          outs.insert(outs.size(), CH_SPACE);
          mode = MODE_LIT;
        end
        default: begin
          if (b == CH_SLASH && !l) begin
            mode = MODE_SLASH;
          end else begin
            plain_text(b, outs);
          end
        end
      endcase
      foreach (outs[i]) begin
        beat.data = outs[i];
        beat.last = l && (i == outs.size() - 1);
        blanked_q.insert(blanked_q.size(), beat);
      end
      if (l) begin
        mode         = MODE_PLAIN;
        single_quote = 1'b0;
      end
    endfunction

    task check_result(logic [7:0] b, logic l);
      blank_beat_t want;
      if (blanked_q.size() == 0) begin
        report("unexpected out beat", 8'h00, b);
        return;
      end
      want = blanked_q.pop_front();
      if (b !== want.data) report("out_byte", want.data, b);
      if (l !== want.last) report("out_last", {7'd0, want.last}, {7'd0, l});
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       src_valid_i;
  logic       src_stall_o;
  logic [7:0] src_byte_i;
  logic       src_last_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  blank_scoreboard sb;
  logic [7:0]      src_text[$];
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     quiet_cycles;
  int unsigned     phase_sent;

  c_source_comment_string_blanker_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_valid_i (src_valid_i),
    .src_stall_o (src_stall_o),
    .src_byte_i  (src_byte_i),
    .src_last_i  (src_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The receiver decides afresh at every falling edge whether it stalls.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Both channels are sampled at the rising edge, before the block updates.
  // An input beat is noted before an output beat is checked, so a result of
  // the same edge would still find its expectation.
  always @(posedge clk_i) begin
    if (src_valid_i && !src_stall_o) sb.note_input(src_byte_i, src_last_i);
    if (out_valid_o && !out_stall_i) sb.check_result(out_byte_o, out_last_o);
    if ((src_valid_i && !src_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

  // Watchdog: a run that stops moving ends here.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("ERROR: no beat accepted for %0d cycles", QUIET_LIMIT);
    $display("c_source_comment_string_blanker_top_tb failed");
    $finish;
  end

  // Drive one input beat, with random idle cycles in front of it, and hold
  // it until the block takes it.
  task send_beat(input logic [7:0] b, input logic l);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      src_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    src_valid_i <= 1'b1;
    src_byte_i  <= b;
    src_last_i  <= l;
    @(posedge clk_i);
    while (src_stall_o) @(posedge clk_i);
  endtask

  // Send the prepared text; its final byte carries the end mark.
  task send_text();
    foreach (src_text[i]) send_beat(src_text[i], i == src_text.size() - 1);
    phase_sent += src_text.size();
  endtask

  // Hold the sender off until every owed output beat has come out.
  task wait_drained();
    @(negedge clk_i);
    src_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Half of the picks land on a space or on the bytes the scanner reacts to.
  function logic [7:0] pick_byte();
    case ($urandom_range(13))
      0:       return CH_SPACE;
      1:       return CH_NL;
      2:       return CH_SLASH;
      3:       return CH_STAR;
      4:       return CH_DQUOTE;
      5:       return CH_SQUOTE;
      6:       return CH_BSLASH;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Append one byte to the text being built.
  function void add_byte(input logic [7:0] b);
    src_text.insert(src_text.size(), b);
  endfunction

  // Build a random text out of mostly well-formed pieces: plain runs,
  // comments, literals with escapes, lone slashes, plus some loose noise.
  // Cutting the text to its length leaves some comments or literals open.
  function void build_text();
    int unsigned target;
    logic [7:0]  quote;
    src_text.delete();
    target = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    while (src_text.size() < target) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
        end
        3: begin
          add_byte(CH_SLASH);
          add_byte(CH_SLASH);
          repeat ($urandom_range(0, 8)) add_byte(pick_byte());
          add_byte(CH_NL);
        end
        4: begin
          add_byte(CH_SLASH);
          add_byte(CH_STAR);
          repeat ($urandom_range(0, 8)) begin
            add_byte($urandom_range(1) ? pick_byte() : CH_STAR);
          end
          add_byte(CH_STAR);
          add_byte(CH_SLASH);
        end
        5, 6: begin
          quote = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
          add_byte(quote);
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(3) == 0) add_byte(CH_BSLASH);
            add_byte(pick_byte());
          end
          add_byte(quote);
        end
        7: begin
          add_byte(CH_SLASH);
          add_byte(pick_byte());
        end
        default: begin
          repeat ($urandom_range(1, 4)) add_byte(pick_byte());
        end
      endcase
    end
    while (src_text.size() > target) src_text.delete(src_text.size() - 1);
  endfunction

  initial begin
    int unsigned send_idle_by_phase[NUM_PHASES];
    int unsigned recv_stall_by_phase[NUM_PHASES];
    send_idle_by_phase  = '{0, 62, 0, 25};
    recv_stall_by_phase = '{0, 0, 62, 25};
    sb             = new();
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    src_valid_i    = 1'b0;
    src_byte_i     = 8'h00;
    src_last_i     = 1'b0;
    out_stall_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    phase_sent     = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed texts, sent back to back with no idling.
    // A slash as the whole text is passed through at once.
    src_text = '{CH_SLASH};
    send_text();
    // A held slash followed by a quote, then a literal left open.
    src_text = '{CH_SLASH, CH_SQUOTE, 8'h61};
    send_text();
    // Line comment ended by a kept newline, a held slash resolved as text,
    // a block comment whose opening star does not close on the next slash
    // and that closes on a doubled star, a literal with an escaped newline
    // and a foreign quote inside, then the byte extremes in plain text.
    src_text = '{CH_SLASH, CH_SLASH, 8'h7A, CH_NL, CH_SLASH, 8'h41,
                 CH_SLASH, CH_STAR, CH_SLASH, CH_STAR, CH_STAR, CH_SLASH,
                 CH_DQUOTE, CH_BSLASH, CH_NL, CH_SQUOTE, CH_DQUOTE,
                 8'hFF, 8'h00};
    send_text();
    // A block comment that runs to the end of the text.
    src_text = '{CH_SLASH, CH_STAR, 8'h71};
    send_text();

    // Random texts, one idling pattern per phase. Each phase starts from a
    // drained block, and now and then the sender waits for the drain
    // between texts as well.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      send_idle_pct  = send_idle_by_phase[p];
      recv_stall_pct = recv_stall_by_phase[p];
      phase_sent     = 0;
      while (phase_sent < PHASE_BEATS) begin
        build_text();
        send_text();
        if ($urandom_range(7) == 0) wait_drained();
      end
    end

    // Let the last beats drain, then give the block a few more cycles to
    // show any beat it should not produce.
    @(negedge clk_i);
    src_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("c_source_comment_string_blanker_top_tb passed");
    end else begin
      $display("c_source_comment_string_blanker_top_tb failed");
    end
    $finish;
  end

endmodule
